>>> rtl/occgrid_pkg.sv
// Shared types and constants for the occupancy grid store with run-length dump.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps
package occgrid_pkg;

	localparam int GRID_RADIUS_DEF = 127;
	localparam int IDX_W   = 16;
	localparam int CM_W    = 14;
	localparam int COORD_W = 8;
	localparam int QDEPTH  = 2;

	localparam logic [1:0] FUNC_SET   = 2'd0;
	localparam logic [1:0] FUNC_GET   = 2'd1;
	localparam logic [1:0] FUNC_START = 2'd2;
	localparam logic [1:0] FUNC_POLL  = 2'd3;

	localparam logic KIND_RUN  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [7:0] CELL_UNKNOWN = 8'hFF;
	localparam logic [1:0] DUMPS_ON_START = 2'd2;

	// x / 10 == (x * 52429) >> 19 for every x below 43690
	localparam logic [15:0] DIV10_RECIP = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

	typedef struct packed {
		logic [1:0]          func;
		logic signed [15:0]  x_mm;
		logic signed [15:0]  y_mm;
		logic signed [7:0]   value_in;
	} cmd_t;

	typedef struct packed {
		logic                reply_kind;
		logic signed [7:0]   cell_value;
		logic [15:0]         start_index;
		logic [15:0]         run_length;
		logic                in_grid;
	} result_t;

	// Classified item handed from front to back.
	typedef struct packed {
		logic [1:0]       func;
		logic             in_grid;
		logic [IDX_W-1:0] idx;
		logic [7:0]       value;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

>>> rtl/occgrid_front.sv
// Front end: accepts items, rounds millimetres to centimetres and forms the cell index.
// Depends on occgrid_pkg.
`timescale 1ns / 1ps
module occgrid_front #(
	parameter int GRID_RADIUS = occgrid_pkg::GRID_RADIUS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  occgrid_pkg::cmd_t          cmd,
	input  occgrid_pkg::queue_status_t qstat,
	input  logic                       clearing,
	output logic                       busy,
	output logic                       push,
	output occgrid_pkg::op_t           push_op
);

	localparam int DIM = 2 * GRID_RADIUS + 1;

	function automatic logic signed [occgrid_pkg::CM_W-1:0] mm_to_cm(
		input logic signed [15:0] mm);
		logic signed [16:0] t;
		logic neg;
		logic [15:0] mag;
		logic [31:0] prod;
		logic [12:0] q;
		logic signed [occgrid_pkg::CM_W-1:0] qs;
		t    = (mm > 16'sd0) ? ($signed({mm[15], mm}) + 17'sd5)
		                     : ($signed({mm[15], mm}) - 17'sd4);
		neg  = t[16];
		mag  = neg ? 16'(-t) : t[15:0];
		prod = 32'(mag) * 32'(occgrid_pkg::DIV10_RECIP);
		q    = prod[occgrid_pkg::DIV10_SHIFT+12:occgrid_pkg::DIV10_SHIFT];
		qs   = $signed({1'b0, q});
		return neg ? -qs : qs;
	endfunction

	logic                                  v_s1;
	occgrid_pkg::cmd_t                     cmd_s1;
	logic                                  v_s2;
	logic [1:0]                            func_s2;
	logic [7:0]                            value_s2;
	logic signed [occgrid_pkg::CM_W-1:0]   xcm_s2;
	logic signed [occgrid_pkg::CM_W-1:0]   ycm_s2;
	logic signed [14:0]                    col;
	logic signed [14:0]                    row;
	logic                                  accept;

	assign busy   = clearing || v_s1 || v_s2 || qstat.full;
	assign accept = start && !busy;
	assign push   = v_s2 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (v_s1) begin
				v_s1 <= 1'b0;
			end
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (push) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (v_s1) begin
			func_s2  <= cmd_s1.func;
			value_s2 <= cmd_s1.value_in;
			xcm_s2   <= mm_to_cm(cmd_s1.x_mm);
			ycm_s2   <= mm_to_cm(cmd_s1.y_mm);
		end
	end

	always_comb begin
		col = 15'(GRID_RADIUS) + 15'(xcm_s2);
		row = 15'(GRID_RADIUS) - 15'(ycm_s2);
		push_op.func    = func_s2;
		push_op.value   = value_s2;
		push_op.in_grid = (col >= 15'sd0) && (col < $signed(15'(DIM)))
		               && (row >= 15'sd0) && (row < $signed(15'(DIM)));
		push_op.idx     = occgrid_pkg::IDX_W'(row[occgrid_pkg::COORD_W-1:0])
		                * occgrid_pkg::IDX_W'(DIM)
		                + occgrid_pkg::IDX_W'(col[occgrid_pkg::COORD_W-1:0]);
	end

endmodule

>>> rtl/occgrid_queue.sv
// Short in-order queue between front and back end.
// Depends on occgrid_pkg.
`timescale 1ns / 1ps
module occgrid_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  occgrid_pkg::op_t           push_op,
	input  logic                       pop,
	output occgrid_pkg::op_t           head,
	output occgrid_pkg::queue_status_t qstat
);

	localparam int PTR_W = $clog2(occgrid_pkg::QDEPTH);

	occgrid_pkg::op_t   slot_q [occgrid_pkg::QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     cnt_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == (PTR_W+1)'(occgrid_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

>>> rtl/occgrid_back.sv
// Back end: cell memory, clearing pass, set/get execution and run-length walk.
// Depends on occgrid_pkg.
`timescale 1ns / 1ps
module occgrid_back #(
	parameter int GRID_RADIUS = occgrid_pkg::GRID_RADIUS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  occgrid_pkg::queue_status_t qstat,
	input  occgrid_pkg::op_t           head,
	output logic                       pop,
	output logic                       clearing,
	output logic                       res_strobe,
	output occgrid_pkg::result_t       res
);

	localparam int DIM    = 2 * GRID_RADIUS + 1;
	localparam int COUNT  = DIM * DIM;
	localparam int ADDR_W = $clog2(COUNT);
	localparam int IW     = occgrid_pkg::IDX_W;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SET   = 3'd2;
	localparam logic [2:0] S_GET   = 3'd3;
	localparam logic [2:0] S_PCUR  = 3'd4;
	localparam logic [2:0] S_PWALK = 3'd5;

	logic [7:0]        cell_mem [COUNT];
	logic [7:0]        rdata_q;

	logic [2:0]        state_q, state_d;
	logic [ADDR_W-1:0] clr_addr_q;
	occgrid_pkg::op_t  op_q;
	logic [IW-1:0]     pos_q, pos_d;
	logic [1:0]        dumps_q, dumps_d;
	logic [IW-1:0]     start_q, start_d;
	logic [IW-1:0]     p_q, p_d;
	logic [7:0]        cur_q, cur_d;
	logic              res_strobe_q, emit;
	occgrid_pkg::result_t res_q, res_d;

	logic [IW-1:0]     raddr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic              fin;
	logic [IW-1:0]     fin_p;
	logic [7:0]        fin_val;
	logic [IW:0]       next_p;
	logic [IW-1:0]     poll_start;

	assign clearing   = (state_q == S_CLR);
	assign res_strobe = res_strobe_q;
	assign res        = res_q;
	assign pop        = (state_q == S_IDLE) && !qstat.empty;

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		dumps_d = dumps_q;
		start_d = start_q;
		p_d     = p_q;
		cur_d   = cur_q;
		emit    = 1'b0;
		res_d   = res_q;
		raddr   = '0;
		we      = 1'b0;
		waddr   = clr_addr_q;
		wdata   = occgrid_pkg::CELL_UNKNOWN;
		fin     = 1'b0;
		fin_p   = p_q;
		fin_val = cur_q;
		next_p  = {1'b0, p_q} + 1'b1;
		poll_start = (pos_q >= IW'(COUNT)) ? '0 : pos_q;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1;
				if (clr_addr_q == ADDR_W'(COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (pop) begin
					unique case (head.func)
						occgrid_pkg::FUNC_SET: begin
							raddr = head.idx;
							if (head.in_grid) begin
								state_d = S_SET;
							end
						end
						occgrid_pkg::FUNC_GET: begin
							raddr = head.idx;
							if (head.in_grid) begin
								state_d = S_GET;
							end else begin
								emit  = 1'b1;
								res_d = '{occgrid_pkg::KIND_READ,
									occgrid_pkg::CELL_UNKNOWN, '0, '0, 1'b0};
							end
						end
						occgrid_pkg::FUNC_START: begin
							dumps_d = occgrid_pkg::DUMPS_ON_START;
						end
						occgrid_pkg::FUNC_POLL: begin
							if (dumps_q != 2'd0) begin
								raddr   = poll_start;
								start_d = poll_start;
								state_d = S_PCUR;
							end
						end
						default: ;
					endcase
				end
			end
			S_SET: begin
				state_d = S_IDLE;
				if (rdata_q != op_q.value) begin
					we    = 1'b1;
					waddr = op_q.idx[ADDR_W-1:0];
					wdata = op_q.value;
					emit  = 1'b1;
					res_d = '{occgrid_pkg::KIND_RUN, op_q.value, op_q.idx, IW'(1), 1'b0};
				end
			end
			S_GET: begin
				state_d = S_IDLE;
				emit    = 1'b1;
				res_d   = '{occgrid_pkg::KIND_READ, rdata_q, op_q.idx, '0, 1'b1};
			end
			S_PCUR: begin
				// first cell of the run sets its value
				cur_d   = rdata_q;
				fin_val = rdata_q;
				next_p  = {1'b0, start_q} + 1'b1;
				if (next_p >= (IW+1)'(COUNT)) begin
					fin   = 1'b1;
					fin_p = IW'(COUNT);
				end else begin
					raddr   = next_p[IW-1:0];
					p_d     = next_p[IW-1:0];
					state_d = S_PWALK;
				end
			end
			S_PWALK: begin
				if (rdata_q == cur_q) begin
					if (next_p >= (IW+1)'(COUNT)) begin
						fin   = 1'b1;
						fin_p = IW'(COUNT);
					end else begin
						raddr = next_p[IW-1:0];
						p_d   = next_p[IW-1:0];
					end
				end else begin
					fin   = 1'b1;
					fin_p = p_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
			emit    = 1'b1;
			res_d   = '{occgrid_pkg::KIND_RUN, fin_val, start_q, fin_p - start_q, 1'b0};
			if (fin_p == IW'(COUNT)) begin
				pos_d   = '0;
				dumps_d = dumps_q - 2'd1;
			end else begin
				pos_d = fin_p;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_addr_q   <= '0;
			pos_q        <= '0;
			dumps_q      <= '0;
			res_strobe_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			pos_q        <= pos_d;
			dumps_q      <= dumps_d;
			res_strobe_q <= emit;
			if (state_q == S_CLR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
		start_q <= start_d;
		p_q     <= p_d;
		cur_q   <= cur_d;
		res_q   <= res_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			cell_mem[waddr] <= wdata;
		end
		rdata_q <= cell_mem[raddr[ADDR_W-1:0]];
	end

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !res_strobe_q)
		else $error("result strobe during clearing pass");

	a_dumps_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		dumps_q != 2'd3)
		else $error("dump counter out of range");

	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < IW'(COUNT))
		else $error("dump position past grid end");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe_q && res_q.reply_kind == occgrid_pkg::KIND_RUN)
		|-> (res_q.run_length != '0))
		else $error("empty run emitted");

endmodule

>>> rtl/occupancy_grid_store_rle_dump_top.sv
// Top level of the occupancy grid store with run-length dump.
// Depends on occgrid_pkg, occgrid_front, occgrid_queue and occgrid_back.
`timescale 1ns / 1ps
// Usage: after reset the block runs a clearing pass that writes every cell to
// unknown (-1), one cell per cycle, (2*GRID_RADIUS+1)^2 cells, 65025 at the
// default radius; busy stays high throughout. An item is taken when start is
// high and busy is low. The front end registers the item, then registers the
// divide-by-ten multiply of the millimetres, and forms the cell index with a
// combinational multiply-add; it hands the item through a two-entry queue, so
// busy falls again while the back end still works. The back end owns the cell
// memory, with one read and one write port: a set or get inside the grid reads
// the cell and then acts on it, one outside it and a start are done while idle,
// and a poll walks its run from the first cell (up to the whole grid). Each
// result shows on res for exactly one cycle with res_strobe high; the receiver
// cannot stall it, so sample it on that cycle or lose it.
module occupancy_grid_store_rle_dump_top #(
	parameter int GRID_RADIUS = occgrid_pkg::GRID_RADIUS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  occgrid_pkg::cmd_t    cmd,
	output logic                 busy,
	output logic                 res_strobe,
	output occgrid_pkg::result_t res
);

	occgrid_pkg::queue_status_t qstat;
	occgrid_pkg::op_t           push_op;
	occgrid_pkg::op_t           head;
	logic                       push;
	logic                       pop;
	logic                       clearing;

	// classify and locate each item
	occgrid_front #(.GRID_RADIUS(GRID_RADIUS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.qstat    (qstat),
		.clearing (clearing),
		.busy     (busy),
		.push     (push),
		.push_op  (push_op)
	);

	// hold located items in order until the back end is free
	occgrid_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	// execute against the cell memory and drive results
	occgrid_back #(.GRID_RADIUS(GRID_RADIUS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.res_strobe (res_strobe),
		.res        (res)
	);

endmodule
